// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("assertion failed");

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

// ----- hdl/olid_pkg.sv -----
// ----------------------------------------------------------------------------
// olid_pkg
// Shared codes and controller/datapath interface types for the list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // controller to datapath
    typedef struct packed {
        logic ld;        // latch the incoming transaction
        logic rd_next;   // read entry at the scan pointer, advance pointer
        logic rd_pos;    // read entry at the requested position
        logic seek;      // restart scan just behind the matched entry
        logic wr_tail;   // append value, bump count
        logic wr_shift;  // move the read entry one place towards the head
        logic dec;       // drop one from the count
        logic set_ok;    // mark the command as successful
        logic out_load;  // load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       empty;
        logic       pos_ok;
        logic       match;
        logic       dv;
        logic       more;
        logic       last_data;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/ordered_list_insert_delete_core.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// Bounded ordered list of 32-bit values with append, delete-first-match and
// read-by-position commands; one result per command.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                                   tuser
// s_axis    in   [31:0] value, [35:32] position          [1:0] cmd
// m_axis    out  [4:0] count, [36:5] read_value          [0] ok
//
// Append writes the value at the tail and bumps the count in decode; read
// reads the entry at the requested position, waits for the data, then loads
// the result register. Delete scans the list with one memory read port, an
// entry a cycle up to the match, then moves each later entry one place
// forward, one a cycle; a delete that finds nothing ends at the last entry.
// One command is in progress at a time; the result register lets the next
// command be accepted while a result waits on m_tready.
// Reset clears the count, scan pointers, data-valid flag and result valid;
// entry storage needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete_core #(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], position[35:32], zero pad
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // count[4:0], read_value[36:5], zero pad
    output logic [0:0]       m_tuser    // ok[0]
);
    import olid_pkg::*;

    ctrl_cmd_t          ctrl;
    dp_status_t         status;
    logic               res_ok;
    logic [4:0]         res_count;
    logic signed [31:0] res_read_value;

    olid_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    olid_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .status         (status),
        .in_cmd         (s_tuser),
        .in_value       (s_tdata[31:0]),
        .in_position    (s_tdata[35:32]),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_ok         (res_ok),
        .res_count      (res_count),
        .res_read_value (res_read_value)
    );

    assign m_tdata = {3'b000, res_read_value, res_count};
    assign m_tuser = res_ok;

endmodule

`default_nettype wire

// ----- hdl/olid_datapath.sv -----
// ----------------------------------------------------------------------------
// olid_datapath
// Entry memory, count, scan pointers and result register of the list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module olid_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire olid_pkg::ctrl_cmd_t          ctrl,
    output olid_pkg::dp_status_t              status,
    input  wire logic [1:0]                   in_cmd,
    input  wire logic signed [31:0]           in_value,
    input  wire logic [3:0]                   in_position,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic                              res_ok,
    output logic [4:0]                        res_count,
    output logic signed [31:0]                res_read_value
);
    import olid_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]      data_idx_reg, data_idx_next;
    logic               dv_reg;
    logic [VALUE_W-1:0] rdata_reg;
    logic [1:0]         cmd_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               ok_reg;
    logic               m_valid_reg;
    logic               m_ok_reg;
    logic [4:0]         m_count_reg;
    logic [VALUE_W-1:0] m_rdval_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    // memory port selection
    always_comb
    begin
        mem_we    = ctrl.wr_tail | ctrl.wr_shift;
        mem_waddr = ctrl.wr_tail ? count_reg[AW-1:0] : (data_idx_reg - AW'(1));
        mem_wdata = ctrl.wr_tail ? value_reg : rdata_reg;
        mem_re    = ctrl.rd_next | ctrl.rd_pos;
        mem_raddr = ctrl.rd_pos ? AW'(pos_reg) : rd_ptr_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.wr_tail)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.dec)
        begin
            count_next = count_reg - CW'(1);
        end

        rd_ptr_next   = rd_ptr_reg;
        data_idx_next = data_idx_reg;
        if (ctrl.ld)
        begin
            rd_ptr_next = '0;
        end
        else if (ctrl.seek)
        begin
            rd_ptr_next = CW'(data_idx_reg) + CW'(1);
        end
        else if (ctrl.rd_next)
        begin
            rd_ptr_next   = rd_ptr_reg + CW'(1);
            data_idx_next = rd_ptr_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            data_idx_reg <= '0;
            dv_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            data_idx_reg <= data_idx_next;
            dv_reg       <= ctrl.rd_next;
            if (ctrl.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld)
        begin
            cmd_reg   <= in_cmd;
            value_reg <= in_value;
            pos_reg   <= in_position;
            ok_reg    <= 1'b0;
        end
        else if (ctrl.set_ok)
        begin
            ok_reg <= 1'b1;
        end
        if (ctrl.out_load)
        begin
            m_ok_reg    <= ok_reg;
            m_count_reg <= 5'(count_reg);
            m_rdval_reg <= (ok_reg && cmd_reg == CMD_READ) ? rdata_reg : '0;
        end
    end

    always_comb
    begin
        status.cmd       = cmd_reg;
        status.full      = (count_reg == CW'(DEPTH));
        status.empty     = (count_reg == '0);
        status.pos_ok    = (CMPW'(pos_reg) < CMPW'(count_reg));
        status.match     = (rdata_reg == value_reg);
        status.dv        = dv_reg;
        status.more      = (rd_ptr_reg < count_reg);
        status.last_data = (CW'(data_idx_reg) == (count_reg - CW'(1)));
        status.out_free  = !m_valid_reg || res_ready;
    end

    assign res_valid      = m_valid_reg;
    assign res_ok         = m_ok_reg;
    assign res_count      = m_count_reg;
    assign res_read_value = m_rdval_reg;

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(DEPTH))
    `ASSERT_PROP(a_shift_has_data, clk, rst_n, ctrl.wr_shift |-> dv_reg)
    `ASSERT_PROP(a_load_when_free, clk, rst_n, ctrl.out_load |-> (!m_valid_reg || res_ready))
    `ASSERT_PROP(a_count_step, clk, rst_n,
        (ctrl.wr_tail || ctrl.dec) |=> (count_reg != $past(count_reg)))

endmodule

`default_nettype wire

// ----- hdl/olid_controller.sv -----
// ----------------------------------------------------------------------------
// olid_controller
// Command sequencer: decode, linear search, gap closing and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olid_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire olid_pkg::dp_status_t status,
    output olid_pkg::ctrl_cmd_t       ctrl
);
    import olid_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_SEARCH = 6'b000100,
        ST_SHIFT  = 6'b001000,
        ST_RDWAIT = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.ld    = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                case (status.cmd)
                    CMD_APPEND:
                    begin
                        if (!status.full)
                        begin
                            ctrl.wr_tail = 1'b1;
                            ctrl.set_ok  = 1'b1;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (!status.empty)
                        begin
                            ctrl.rd_next = 1'b1;
                            state_next   = ST_SEARCH;
                        end
                    end
                    CMD_READ:
                    begin
                        if (status.pos_ok)
                        begin
                            ctrl.rd_pos = 1'b1;
                            ctrl.set_ok = 1'b1;
                            state_next  = ST_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SEARCH:
            begin
                // compare the entry read last cycle while the next read is in flight
                if (status.dv && status.match)
                begin
                    ctrl.set_ok = 1'b1;
                    ctrl.seek   = 1'b1;
                    state_next  = ST_SHIFT;
                end
                else if (status.dv && status.last_data)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.more)
                begin
                    ctrl.rd_next = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                ctrl.wr_shift = status.dv;
                if (status.more)
                begin
                    ctrl.rd_next = 1'b1;
                end
                else
                begin
                    ctrl.dec   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/ordered_list_insert_delete_core_tb.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core_tb
// Drives append, delete and read commands into the list core over the
// s_axis side and checks every m_axis result against a shadow copy of the
// list kept in the testbench, or against a result typed into the directed
// table. That table covers the empty and full list, the extreme values,
// duplicates and the unused command code. A random part follows, with fill
// and drain phases and bursty traffic on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_insert_delete_core_tb;

    import olid_pkg::*;

    localparam int         LIST_DEPTH  = 16;
    localparam int         RAND_ITEMS  = 600;
    localparam int         DIR_ROWS    = 25;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic        ok;
        logic [4:0]  count;
        logic [31:0] read_value;
    } list_result_t;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [31:0]  value;
        logic [3:0]   pos;
        logic [4:0]   reps;       // repeat the row, value stepped by one each time
        logic         use_fixed;  // expected result typed in below
        list_result_t fixed_res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // value[31:0], position[35:32], zero pad
    logic [1:0]  s_tuser;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // count[4:0], read_value[36:5], zero pad
    logic [0:0]  m_tuser;   // ok[0]

    // shadow copy of the list, updated at each accepted command
    logic [31:0]  shadow_mem [LIST_DEPTH];
    int           shadow_len;
    list_result_t awaited_answers [$];
    int           err_cnt;
    int           burst_left;
    int           gap_len;
    stim_row_t    dir_tab [DIR_ROWS];

    ordered_list_insert_delete_core #(
        .DEPTH (LIST_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic list_result_t apply_list_cmd(input logic [1:0] cmd,
                                                    input logic [31:0] value,
                                                    input logic [3:0] pos);
        list_result_t res;
        int           hit;
        res = '0;
        hit = -1;
        case (cmd)
            CMD_APPEND:
            begin
                if (shadow_len < LIST_DEPTH)
                begin
                    shadow_mem[shadow_len] = value;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                for (int j = 0; j < shadow_len; j++)
                    if (hit < 0 && shadow_mem[j] == value)
                        hit = j;
                if (hit >= 0)
                begin
                    // close the gap, keep the order of the rest
                    for (int j = hit; j < shadow_len - 1; j++)
                        shadow_mem[j] = shadow_mem[j + 1];
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (int'(pos) < shadow_len)
                begin
                    res.ok         = 1'b1;
                    res.read_value = shadow_mem[pos];
                end
            end
            default: ;
        endcase
        res.count = 5'(shadow_len);
        return res;
    endfunction

    function automatic logic [31:0] pick_pool_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h0000_0000;
            1:       v = 32'h0000_0001;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h8000_0000;
            4:       v = 32'h7FFF_FFFF;
            5:       v = 32'h0000_002A;
            6:       v = 32'h5555_5555;
            default: v = 32'hAAAA_AAAA;
        endcase
        return v;
    endfunction

    // Present one command; bursts of back-to-back transactions are mostly separated
    // by random gaps with tvalid low.
    task automatic push_cmd(input logic [1:0] cmd, input logic [31:0] value,
                            input logic [3:0] pos, input logic use_fixed,
                            input list_result_t fixed_res);
        list_result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap_len - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pos, value};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        res = apply_list_cmd(cmd, value, pos);
        awaited_answers.push_back(use_fixed ? fixed_res : res);
    endtask

    // receiver: stall pattern re-picks one of three random modes periodically
    initial
    begin
        int stall_left;
        int rx_mode;
        int mode_cycles;
        stall_left  = 0;
        rx_mode     = 0;
        mode_cycles = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(negedge clk);
            mode_cycles++;
            if (mode_cycles == 150)
            begin
                mode_cycles = 0;
                rx_mode     = $urandom_range(0, 2);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_mode == 1 && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                m_tready  <= 1'b0;
            end
            else if (rx_mode == 2 && $urandom_range(0, 24) == 0)
            begin
                stall_left = $urandom_range(5, 20) - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result checker
    initial
    begin
        list_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: unexpected result ok=%0d count=%0d read_value=%h",
                             $realtime, m_tuser[0], m_tdata[4:0], m_tdata[36:5]);
                    err_cnt++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (m_tuser[0] !== want.ok)
                    begin
                        $display("%0t: ok mismatch: expected %0d actual %0d",
                                 $realtime, want.ok, m_tuser[0]);
                        err_cnt++;
                    end
                    if (m_tdata[4:0] !== want.count)
                    begin
                        $display("%0t: count mismatch: expected %0d actual %0d",
                                 $realtime, want.count, m_tdata[4:0]);
                        err_cnt++;
                    end
                    if (m_tdata[36:5] !== want.read_value)
                    begin
                        $display("%0t: read_value mismatch: expected %h actual %h",
                                 $realtime, want.read_value, m_tdata[36:5]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        int           r;
        int           n;
        int           bias;
        int           bias_left;
        logic [1:0]   c;
        logic [31:0]  v;
        logic [3:0]   p;

        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_APPEND;
        rst_n      = 1'b0;
        err_cnt    = 0;
        shadow_len = 0;
        burst_left = 0;
        gap_len    = 0;

        //             cmd         value          pos    reps   fixed  ok  count  read_value
        dir_tab = '{
            '{CMD_READ,   32'h0000_0000, 4'd0,  5'd1,  1'b1, '{1'b0, 5'd0,  32'h0}},
            '{CMD_DELETE, 32'h0000_0005, 4'd0,  5'd1,  1'b1, '{1'b0, 5'd0,  32'h0}},
            '{CMD_UNUSED, 32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1, '{1'b0, 5'd0,  32'h0}},
            '{CMD_APPEND, 32'h8000_0000, 4'd0,  5'd1,  1'b1, '{1'b1, 5'd1,  32'h0}},
            '{CMD_APPEND, 32'h7FFF_FFFF, 4'd0,  5'd1,  1'b1, '{1'b1, 5'd2,  32'h0}},
            '{CMD_APPEND, 32'h0000_0000, 4'd0,  5'd1,  1'b1, '{1'b1, 5'd3,  32'h0}},
            '{CMD_APPEND, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1, '{1'b1, 5'd4,  32'h0}},
            '{CMD_READ,   32'h0000_0000, 4'd0,  5'd1,  1'b1, '{1'b1, 5'd4,  32'h8000_0000}},
            '{CMD_READ,   32'h0000_0000, 4'd1,  5'd1,  1'b1, '{1'b1, 5'd4,  32'h7FFF_FFFF}},
            '{CMD_READ,   32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1, '{1'b0, 5'd4,  32'h0}},
            '{CMD_READ,   32'h0000_0000, 4'd4,  5'd1,  1'b1, '{1'b0, 5'd4,  32'h0}},
            '{CMD_APPEND, 32'h7FFF_FFFF, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_DELETE, 32'h7FFF_FFFF, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_READ,   32'h0000_0000, 4'd1,  5'd1,  1'b0, '0},
            '{CMD_READ,   32'h0000_0000, 4'd3,  5'd1,  1'b0, '0},
            '{CMD_DELETE, 32'h1234_5678, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_UNUSED, 32'h0000_0000, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_APPEND, 32'h0000_0100, 4'd0,  5'd11, 1'b0, '0},
            '{CMD_APPEND, 32'hA5A5_A5A5, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_APPEND, 32'h0000_0001, 4'd0,  5'd1,  1'b1, '{1'b0, 5'd16, 32'h0}},
            '{CMD_READ,   32'h0000_0000, 4'd15, 5'd1,  1'b0, '0},
            '{CMD_DELETE, 32'hA5A5_A5A5, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_DELETE, 32'h8000_0000, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_READ,   32'h0000_0000, 4'd0,  5'd1,  1'b0, '0},
            '{CMD_DELETE, 32'h0000_0105, 4'd0,  5'd1,  1'b0, '0}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            for (int k = 0; k < int'(dir_tab[i].reps); k++)
                push_cmd(dir_tab[i].cmd, dir_tab[i].value + 32'(k), dir_tab[i].pos,
                         dir_tab[i].use_fixed, dir_tab[i].fixed_res);

        // random part: alternate fill, drain and balanced phases so the list
        // swings between empty and full
        bias      = 0;
        bias_left = 0;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (bias_left == 0)
            begin
                bias      = $urandom_range(0, 2);
                bias_left = $urandom_range(30, 60);
            end
            bias_left--;
            r = $urandom_range(0, 99);
            if (r >= 97)
                c = CMD_UNUSED;
            else if (r < (bias == 0 ? 60 : (bias == 1 ? 15 : 38)))
                c = CMD_APPEND;
            else if (r < (bias == 0 ? 75 : (bias == 1 ? 72 : 70)))
                c = CMD_DELETE;
            else
                c = CMD_READ;

            v = $urandom();
            if (c == CMD_APPEND && $urandom_range(0, 1) == 0)
                v = pick_pool_value();
            if (c == CMD_DELETE)
            begin
                if (shadow_len > 0 && $urandom_range(0, 9) < 7)
                    v = shadow_mem[$urandom_range(0, shadow_len - 1)];
                else if ($urandom_range(0, 1) == 0)
                    v = pick_pool_value();
            end

            // mostly in range or just past the tail
            n = $urandom_range(0, shadow_len);
            if (n > LIST_DEPTH - 1)
                n = LIST_DEPTH - 1;
            p = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'(n);

            push_cmd(c, v, p, 1'b0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (awaited_answers.size() != 0)
            @(posedge clk);
        // drain: a delete of a full list scans and shifts every entry
        repeat (64) @(posedge clk);

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/olid_pkg.sv
hdl/olid_datapath.sv
hdl/olid_controller.sv
hdl/ordered_list_insert_delete_core.sv
tb/ordered_list_insert_delete_core_tb.sv
